@@ rtl/mfb_pkg.sv @@
package mfb_pkg;

	// input item operation codes
	localparam logic [2:0] FN_WRITE   = 3'd0;
	localparam logic [2:0] FN_READ    = 3'd1;
	localparam logic [2:0] FN_CLEAR   = 3'd2;
	localparam logic [2:0] FN_AREA    = 3'd3;
	localparam logic [2:0] FN_FULL    = 3'd4;
	localparam logic [2:0] FN_CONTR   = 3'd5;
	localparam logic [2:0] FN_STEP    = 3'd6;

	// result kinds
	localparam logic [1:0] KIND_PIXEL = 2'd0;
	localparam logic [1:0] KIND_CMD   = 2'd1;
	localparam logic [1:0] KIND_DATA  = 2'd2;

	// panel constants
	localparam logic [7:0] COL_ADDR_BASE = 8'h25;
	localparam logic [7:0] ROW_LO_CMD    = 8'h60;
	localparam logic [7:0] ROW_HI_CMD    = 8'h70;
	localparam logic [7:0] COL_HI_CMD    = 8'h10;
	localparam logic [7:0] CONTRAST_CMD  = 8'h81;
	localparam logic [7:0] CONTRAST_BASE = 8'hB5 - 8'd40;
	localparam logic [7:0] CONTRAST_MAX  = 8'd10;
	localparam logic [7:0] BYTE_FIRST    = 8'hF0;
	localparam logic [7:0] BYTE_SECOND   = 8'h0F;

	// refresh emit phases
	localparam logic [2:0] PH_DATA = 3'd4;
	localparam logic [2:0] PH_PAD  = 3'd5;

	// packed result item
	typedef struct packed {
		logic       last;
		logic       refresh_end;
		logic       pixel_out_of_range;
		logic       pixel_value;
		logic [7:0] panel_byte;
		logic [1:0] result_kind;
	} result_t;

endpackage

@@ rtl/mono_frame_buffer_lcd_refresh.sv @@
// Channel | Dir | Fields (tdata low bit up)
// s_axis  | in  | func, px, py, px_end, py_end, color, row_start, row_count, contrast
// m_axis  | out | panel_byte, pixel_value, pixel_out_of_range, refresh_end; tuser kind; tlast
//
// A pixel write reads, modifies and writes back its store byte; a pixel read loads the
// registered store read into the single output register; a refresh data step makes two
// store reads, one per pixel. Prelude, pad and contrast steps load that register directly.
// Clear rows: one store byte per cycle. Contrast: two results.
// After reset a clearing pass zeroes all ROW_BYTES*FRAME_ROWS store bytes;
// no item is taken meanwhile. A stalled output holds the block.
module mono_frame_buffer_lcd_refresh
	import mfb_pkg::*;
#(
	parameter int FRAME_COLS = 160,
	parameter int FRAME_ROWS = 160
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// func[2:0], px, py, px_end, py_end, color, row_start, row_count, contrast; 5 zero pad
	input  logic [71:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// panel_byte[7:0], pixel_value, pixel_out_of_range, refresh_end, 5 zero pad
	output logic [15:0] m_axis_tdata,
	// result_kind[1:0]
	output logic [1:0]  m_axis_tuser,
	output logic        m_axis_tlast
);

	localparam int ROW_BYTES = (FRAME_COLS + 7) / 8;
	localparam int DEPTH     = ROW_BYTES * FRAME_ROWS;
	localparam int AW        = $clog2(DEPTH);
	localparam int CW        = $clog2(ROW_BYTES);

	typedef enum logic [5:0] {
		ST_INIT  = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_RD    = 6'b000100,
		ST_USE   = 6'b001000,
		ST_CLEAR = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	state_t      state_q;
	logic [2:0]  func_q;
	logic [7:0]  x_q, y_q, color_q, contrast_q;
	logic [7:0]  clr_row_q, clr_end_q;
	logic [CW-1:0] clr_col_q;
	logic [AW:0] init_q;
	logic        second_q;

	// refresh state
	logic        ref_act_q, ref_full_q;
	logic [7:0]  cur_row_q, last_row_q, first_col_q, last_col_q, cur_col_q;
	logic [5:0]  col_group_q;
	logic [2:0]  phase_q;

	result_t     res_q;
	logic        out_v_q;

	// memory port
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    wdata, rdata;

	mfb_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	// input fields
	logic [2:0] in_func;
	logic [7:0] in_px, in_py, in_pxe, in_pye, in_color, in_rs, in_rc, in_con;
	assign in_func  = s_axis_tdata[2:0];
	assign in_px    = s_axis_tdata[10:3];
	assign in_py    = s_axis_tdata[18:11];
	assign in_pxe   = s_axis_tdata[26:19];
	assign in_pye   = s_axis_tdata[34:27];
	assign in_color = s_axis_tdata[42:35];
	assign in_rs    = s_axis_tdata[50:43];
	assign in_rc    = s_axis_tdata[58:51];
	assign in_con   = s_axis_tdata[66:59];

	assign s_axis_tready = (state_q == ST_IDLE) && !out_v_q;
	logic acc;
	assign acc = s_axis_tvalid && s_axis_tready;

	// pixel byte address of (x,y); panel refresh address of current pixels
	function automatic logic [AW-1:0] baddr(input logic [7:0] x, input logic [7:0] y);
		logic [AW+8:0] a;
		a = (AW+9)'(y) * (AW+9)'(ROW_BYTES) + (AW+9)'(x[7:3]);
		return a[AW-1:0];
	endfunction

	logic [7:0] fx0, fx1;  // frame rows of the two pixels of a data byte, see below
	logic       v0, v1;
	// data byte covers panel row cur_row, panel columns cur_col and cur_col+1:
	// frame column FRAME_COLS-1-cur_row, frame rows cur_col, cur_col+1
	logic [7:0] fcol;
	logic [8:0] row1;
	assign fcol = 8'(FRAME_COLS - 1) - cur_row_q;
	assign row1 = {1'b0, cur_col_q} + 9'd1;
	assign fx0  = cur_col_q;
	assign fx1  = row1[7:0];
	assign v0   = (cur_row_q < 8'(FRAME_COLS)) && (cur_col_q < 8'(FRAME_ROWS));
	assign v1   = (cur_row_q < 8'(FRAME_COLS)) && (row1 < 9'(FRAME_ROWS));

	// this data byte closes the row
	logic col_wrap;
	assign col_wrap = ({1'b0, cur_col_q} + 9'd2) > {1'b0, last_col_q};

	// two pixels of one data byte sit in different store bytes: two reads
	logic pix0_q;

	// area refresh setup; divide by three as multiply by 171, shift by 9 (exact below 512)
	logic [7:0] ax0, ay0, ax1, ay1, r0, r1, c0, c1, cl, ch, g0, g1;
	always_comb begin
		ax0 = (in_px  > 8'(FRAME_COLS-1)) ? 8'(FRAME_COLS-1) : in_px;
		ax1 = (in_pxe > 8'(FRAME_COLS-1)) ? 8'(FRAME_COLS-1) : in_pxe;
		ay0 = (in_py  > 8'(FRAME_ROWS-1)) ? 8'(FRAME_ROWS-1) : in_py;
		ay1 = (in_pye > 8'(FRAME_ROWS-1)) ? 8'(FRAME_ROWS-1) : in_pye;
		r0  = 8'(FRAME_COLS-1) - ax0;
		r1  = 8'(FRAME_COLS-1) - ax1;
		c0  = ay0;
		c1  = ay1;
		cl  = (c0 < c1) ? c0 : c1;
		ch  = (c0 < c1) ? c1 : c0;
		g0  = 8'((16'(cl) * 16'd171) >> 9);
		g1  = 8'((16'(ch) * 16'd171) >> 9);
	end

	logic [7:0] addr_c;
	assign addr_c = {2'b00, col_group_q} + COL_ADDR_BASE;
	logic [7:0] con_sat;
	assign con_sat = (contrast_q > CONTRAST_MAX) ? CONTRAST_MAX : contrast_q;

	// memory address selection
	always_comb begin
		we    = 1'b0;
		waddr = baddr(x_q, y_q);
		wdata = 8'h00;
		raddr = baddr(x_q, y_q);
		unique case (state_q)
			ST_INIT: begin
				we    = 1'b1;
				waddr = init_q[AW-1:0];
			end
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = baddr(8'({clr_col_q, 3'b000}), clr_row_q);
			end
			ST_RD: begin
				if (func_q == FN_STEP) raddr = baddr(fcol, second_q ? fx1 : fx0);
			end
			ST_USE: begin
				if (func_q == FN_WRITE) begin
					we    = 1'b1;
					wdata = (color_q == 8'd0) ? (rdata & ~(8'h80 >> x_q[2:0]))
						: (rdata | (8'h80 >> x_q[2:0]));
				end
			end
			default: ;
		endcase
	end

	logic bit_rd;
	assign bit_rd = rdata[3'd7 - (func_q == FN_STEP ? fcol[2:0] : x_q[2:0])];

	// main control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			init_q      <= '0;
			out_v_q     <= 1'b0;
			res_q       <= '0;
			ref_act_q   <= 1'b0;
			ref_full_q  <= 1'b0;
			cur_row_q   <= '0;
			last_row_q  <= '0;
			first_col_q <= '0;
			last_col_q  <= '0;
			cur_col_q   <= '0;
			col_group_q <= '0;
			phase_q     <= '0;
			second_q    <= 1'b0;
			pix0_q      <= 1'b0;
			func_q      <= '0;
			x_q         <= '0;
			y_q         <= '0;
			color_q     <= '0;
			contrast_q  <= '0;
			clr_row_q   <= '0;
			clr_end_q   <= '0;
			clr_col_q   <= '0;
		end else begin
			// the contrast state reloads the output itself
			if (m_axis_tvalid && m_axis_tready && state_q != ST_OUT) out_v_q <= 1'b0;
			unique case (state_q)
				ST_INIT: begin
					init_q <= init_q + 1'b1;
					if (init_q == (AW+1)'(DEPTH-1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (acc) begin
						func_q <= in_func;
						unique case (in_func)
							FN_WRITE: begin
								if (in_px < 8'(FRAME_COLS) && in_py < 8'(FRAME_ROWS))
									state_q <= ST_RD;
							end
							FN_READ: begin
								if (in_px < 8'(FRAME_COLS) && in_py < 8'(FRAME_ROWS)) begin
									state_q <= ST_RD;
								end else begin
									res_q   <= '{last: 1'b1, refresh_end: 1'b0,
										pixel_out_of_range: 1'b1, pixel_value: 1'b0,
										panel_byte: 8'h00, result_kind: KIND_PIXEL};
									out_v_q <= 1'b1;
								end
							end
							FN_CLEAR: begin
								clr_row_q <= in_rs;
								clr_col_q <= '0;
								clr_end_q <= ({1'b0, in_rs} + {1'b0, in_rc} > 9'(FRAME_ROWS))
									? 8'(FRAME_ROWS) : 8'(in_rs + in_rc);
								if (in_rs < 8'(FRAME_ROWS) && in_rc != 8'd0)
									state_q <= ST_CLEAR;
							end
							FN_AREA: begin
								ref_act_q   <= 1'b1;
								ref_full_q  <= 1'b0;
								cur_row_q   <= (r0 < r1) ? r0 : r1;
								last_row_q  <= (r0 < r1) ? r1 : r0;
								first_col_q <= 8'(g0 * 8'd3);
								cur_col_q   <= 8'(g0 * 8'd3);
								last_col_q  <= 8'(g1 * 8'd3 + 8'd2);
								col_group_q <= g0[5:0];
								phase_q     <= '0;
							end
							FN_FULL: begin
								ref_act_q   <= 1'b1;
								ref_full_q  <= 1'b1;
								cur_row_q   <= '0;
								last_row_q  <= 8'(FRAME_COLS - 1);
								first_col_q <= '0;
								cur_col_q   <= '0;
								last_col_q  <= 8'(FRAME_ROWS - 1);
								col_group_q <= '0;
								phase_q     <= '0;
							end
							FN_CONTR: begin
								res_q   <= '{last: 1'b0, refresh_end: 1'b0,
									pixel_out_of_range: 1'b0, pixel_value: 1'b0,
									panel_byte: CONTRAST_CMD, result_kind: KIND_CMD};
								out_v_q    <= 1'b1;
								contrast_q <= in_con;
								state_q    <= ST_OUT;
							end
							FN_STEP: begin
								if (ref_act_q) begin
									if (phase_q < PH_DATA) begin
										out_v_q <= 1'b1;
										phase_q <= phase_q + 3'd1;
										res_q <= '{last: 1'b1, refresh_end: 1'b0,
											pixel_out_of_range: 1'b0, pixel_value: 1'b0,
											result_kind: KIND_CMD,
											panel_byte: (phase_q == 3'd0)
												? (ROW_LO_CMD | {4'h0, cur_row_q[3:0]})
												: (phase_q == 3'd1)
												? (ROW_HI_CMD | {4'h0, cur_row_q[7:4]})
												: (phase_q == 3'd2) ? {4'h0, addr_c[3:0]}
												: (COL_HI_CMD | {4'h0, addr_c[7:4]})};
									end else if (phase_q == PH_PAD) begin
										out_v_q <= 1'b1;
										res_q <= '{last: 1'b1,
											refresh_end: cur_row_q >= last_row_q,
											pixel_out_of_range: 1'b0, pixel_value: 1'b0,
											panel_byte: 8'h00, result_kind: KIND_DATA};
										if (cur_row_q >= last_row_q) begin
											ref_act_q <= 1'b0;
											phase_q   <= '0;
										end else begin
											cur_row_q <= cur_row_q + 8'd1;
											cur_col_q <= first_col_q;
											phase_q   <= PH_DATA;
										end
									end else begin
										second_q <= 1'b0;
										state_q  <= ST_RD;
									end
								end
							end
							default: ;
						endcase
						x_q     <= in_px;
						y_q     <= in_py;
						color_q <= in_color;
					end
				end
				ST_RD: begin
					state_q <= ST_USE;
				end
				ST_USE: begin
					unique case (func_q)
						FN_READ: begin
							res_q   <= '{last: 1'b1, refresh_end: 1'b0,
								pixel_out_of_range: 1'b0, pixel_value: bit_rd,
								panel_byte: 8'h00, result_kind: KIND_PIXEL};
							out_v_q <= 1'b1;
							state_q <= ST_IDLE;
						end
						FN_STEP: begin
							if (!second_q) begin
								pix0_q   <= v0 & bit_rd;
								second_q <= 1'b1;
								state_q  <= ST_RD;
							end else begin
								out_v_q <= 1'b1;
								state_q <= ST_IDLE;
								res_q.last               <= 1'b1;
								res_q.pixel_out_of_range <= 1'b0;
								res_q.pixel_value        <= 1'b0;
								res_q.result_kind        <= KIND_DATA;
								res_q.panel_byte <= (pix0_q ? BYTE_FIRST : 8'h00)
									| ((v1 & bit_rd) ? BYTE_SECOND : 8'h00);
								res_q.refresh_end <= col_wrap && !ref_full_q
									&& (cur_row_q >= last_row_q);
								if (!col_wrap) begin
									cur_col_q <= cur_col_q + 8'd2;
								end else if (ref_full_q) begin
									cur_col_q <= cur_col_q + 8'd2;
									phase_q   <= PH_PAD;
								end else if (cur_row_q >= last_row_q) begin
									cur_col_q <= cur_col_q + 8'd2;
									ref_act_q <= 1'b0;
									phase_q   <= '0;
								end else begin
									cur_row_q <= cur_row_q + 8'd1;
									cur_col_q <= first_col_q;
									phase_q   <= '0;
								end
							end
						end
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_CLEAR: begin
					if (clr_col_q == CW'(ROW_BYTES - 1)) begin
						clr_col_q <= '0;
						clr_row_q <= clr_row_q + 8'd1;
						if (clr_row_q + 8'd1 >= clr_end_q) state_q <= ST_IDLE;
					end else begin
						clr_col_q <= clr_col_q + 1'b1;
					end
				end
				ST_OUT: begin
					// first contrast item leaves, second takes its place
					if (m_axis_tready) begin
						res_q   <= '{last: 1'b1, refresh_end: 1'b0,
							pixel_out_of_range: 1'b0, pixel_value: 1'b0,
							panel_byte: 8'(CONTRAST_BASE + {con_sat[4:0], 3'b000}),
							result_kind: KIND_CMD};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tuser  = res_q.result_kind;
	assign m_axis_tlast  = res_q.last;
	assign m_axis_tdata  = {5'd0, res_q.refresh_end,
		res_q.pixel_out_of_range, res_q.pixel_value, res_q.panel_byte};

	// refresh end is flagged only on data items
	a_end_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[10] |-> m_axis_tuser == KIND_DATA)
		else $error("refresh end on non-data item");
	a_no_acc_init: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_INIT |-> !s_axis_tready)
		else $error("item taken during store clear");
	a_oor_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[9] |-> m_axis_tuser == KIND_PIXEL && !m_axis_tdata[8])
		else $error("out of range flag misused");

endmodule

@@ rtl/mfb_ram.sv @@
module mfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 3200
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ tb/tb.sv @@
module tb
	import mfb_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COLS = 160;
	localparam int ROWS = 160;
	localparam int RB = (COLS + 7) / 8;
	localparam int WATCH_LIMIT = 20000;

	// one expected result
	typedef struct {
		logic [1:0] kind;
		logic [7:0] pbyte;
		logic       pval;
		logic       oor;
		logic       rend;
		logic       lst;
	} panel_res_t;

	int errors = 0;

	task automatic report(input string msg);
		$display("MISMATCH: %s", msg);
		errors++;
	endtask

	// frame buffer predictor plus queue of pending results
	class frame_scoreboard;
		bit [7:0] store [RB*ROWS];
		bit active, is_full;
		int unsigned cur_row, last_row, first_col, last_col, cur_col, grp, phase;
		panel_res_t pending[$];

		function automatic void push(logic [1:0] k, logic [7:0] b, logic v, logic o,
				logic e, logic l);
			panel_res_t r;
			r.kind = k; r.pbyte = b; r.pval = v; r.oor = o; r.rend = e; r.lst = l;
			pending.push_back(r);
		endfunction

		function automatic bit pix(int unsigned x, int unsigned y);
			if (x >= COLS || y >= ROWS) return 0;
			return store[y*RB + x/8][7 - x%8];
		endfunction

		function automatic bit ppix(int unsigned r, int unsigned c);
			if (r >= COLS) return 0;
			return pix(COLS - 1 - r, c);
		endfunction

		function automatic void refresh_step();
			logic [7:0] a, b;
			bit e;
			e = 0;
			if (!active) return;
			a = 8'(grp + COL_ADDR_BASE);
			case (phase)
				0: begin push(KIND_CMD, ROW_LO_CMD | 8'(cur_row & 15), 0, 0, 0, 1); phase = 1; return; end
				1: begin push(KIND_CMD, ROW_HI_CMD | 8'((cur_row >> 4) & 15), 0, 0, 0, 1); phase = 2; return; end
				2: begin push(KIND_CMD, {4'h0, a[3:0]}, 0, 0, 0, 1); phase = 3; return; end
				3: begin push(KIND_CMD, COL_HI_CMD | {4'h0, a[7:4]}, 0, 0, 0, 1); phase = 4; return; end
				4: begin
					b = (ppix(cur_row, cur_col) ? BYTE_FIRST : 8'h00) |
						(ppix(cur_row, cur_col + 1) ? BYTE_SECOND : 8'h00);
					cur_col += 2;
					if (cur_col > last_col) begin
						if (is_full) phase = 5;
						else if (cur_row >= last_row) e = 1;
						else begin cur_row++; cur_col = first_col; phase = 0; end
					end
				end
				default: begin
					b = 0;
					if (cur_row >= last_row) e = 1;
					else begin cur_row++; cur_col = first_col; phase = 4; end
				end
			endcase
			if (e) begin active = 0; phase = 0; end
			push(KIND_DATA, b, 0, 0, e, 1);
		endfunction

		function automatic void note_input(logic [71:0] d);
			int unsigned f, x, y, x1, y1, r0, r1, c0, c1, t, s, en, c;
			f = d[2:0]; x = d[10:3]; y = d[18:11];
			case (3'(f))
				FN_WRITE: if (x < COLS && y < ROWS) store[y*RB + x/8][7 - x%8] = (d[42:35] != 0);
				FN_READ: begin
					if (x < COLS && y < ROWS) push(KIND_PIXEL, 0, pix(x, y), 0, 0, 1);
					else push(KIND_PIXEL, 0, 0, 1, 0, 1);
				end
				FN_CLEAR: begin
					s = d[50:43]; en = s + d[58:51];
					if (en > ROWS) en = ROWS;
					for (; s < en; s++) for (int i = 0; i < RB; i++) store[s*RB + i] = 0;
				end
				FN_AREA: begin
					x1 = d[26:19]; y1 = d[34:27];
					if (x > COLS-1) x = COLS-1;
					if (y > ROWS-1) y = ROWS-1;
					if (x1 > COLS-1) x1 = COLS-1;
					if (y1 > ROWS-1) y1 = ROWS-1;
					r0 = COLS-1-x; r1 = COLS-1-x1; c0 = y; c1 = y1;
					if (r0 > r1) begin t = r0; r0 = r1; r1 = t; end
					if (c0 > c1) begin t = c0; c0 = c1; c1 = t; end
					active = 1; is_full = 0; cur_row = r0; last_row = r1;
					first_col = (c0/3)*3; last_col = (c1/3)*3 + 2; cur_col = first_col;
					grp = (c0/3) & 63; phase = 0;
				end
				FN_FULL: begin
					active = 1; is_full = 1; cur_row = 0; last_row = COLS-1;
					first_col = 0; last_col = ROWS-1; cur_col = 0; grp = 0; phase = 0;
				end
				FN_CONTR: begin
					c = d[66:59];
					if (c > CONTRAST_MAX) c = CONTRAST_MAX;
					push(KIND_CMD, CONTRAST_CMD, 0, 0, 0, 0);
					push(KIND_CMD, 8'(CONTRAST_BASE + c*8), 0, 0, 0, 1);
				end
				FN_STEP: refresh_step();
				default: ;
			endcase
		endfunction

		task automatic check_result(logic [15:0] d, logic [1:0] k, logic l);
			panel_res_t r;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result kind=%0d byte=%h", k, d[7:0]));
				return;
			end
			r = pending.pop_front();
			if (k !== r.kind) report($sformatf("kind %0d exp %0d", k, r.kind));
			if (d[7:0] !== r.pbyte) report($sformatf("byte %h exp %h", d[7:0], r.pbyte));
			if (d[8] !== r.pval) report($sformatf("pixel_value %b exp %b", d[8], r.pval));
			if (d[9] !== r.oor) report($sformatf("out_of_range %b exp %b", d[9], r.oor));
			if (d[10] !== r.rend) report($sformatf("refresh_end %b exp %b", d[10], r.rend));
			if (d[15:11] !== 5'b0) report("nonzero pad in result");
			if (l !== r.lst) report($sformatf("tlast %b exp %b", l, r.lst));
		endtask
	endclass

	logic clk = 0, arst_n = 0;
	logic s_axis_tvalid = 0, s_axis_tready;
	logic [71:0] s_axis_tdata = '0;
	logic m_axis_tvalid, m_axis_tready = 0;
	logic [15:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic m_axis_tlast;
	frame_scoreboard fb = new();
	int idle_cycles = 0;
	bit stim_done = 0;

	mono_frame_buffer_lcd_refresh dut (.*);

	initial forever #1 clk = ~clk;

	// accepted items on both sides feed the scoreboard
	always @(posedge clk) begin
		if (arst_n) begin
			idle_cycles++;
			if (s_axis_tvalid && s_axis_tready) begin
				fb.note_input(s_axis_tdata); idle_cycles = 0;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				fb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast); idle_cycles = 0;
			end
			// the post-reset clearing pass counts against the watchdog too
			if (idle_cycles >= WATCH_LIMIT) begin
				$display("watchdog expired");
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 40) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// receiver stalls at random, with stall-free stretches
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			m_axis_tready <= 1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
			n = gap_len();
			if (n > 0) begin
				m_axis_tready <= 0;
				repeat (n) @(posedge clk);
			end
		end
	end

	task automatic send(input logic [2:0] f, input logic [7:0] x, input logic [7:0] y,
			input logic [7:0] x1, input logic [7:0] y1, input logic [7:0] col,
			input logic [7:0] rs, input logic [7:0] rc, input logic [7:0] ct);
		int g;
		g = gap_len();
		if (g > 0) begin
			s_axis_tvalid <= 0;
			repeat (g) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {5'b0, ct, rc, rs, col, y1, x1, y, x, f};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic send_rand(input logic [2:0] f);
		send(f, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	// small coords mostly, occasionally any byte
	function automatic logic [7:0] coord();
		return ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, COLS-1));
	endfunction

	initial begin
		int f, n;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed corners
		send(FN_WRITE, 0, 0, 0, 0, 8'hFF, 0, 0, 0);
		send(FN_WRITE, 159, 159, 0, 0, 1, 0, 0, 0);
		send(FN_WRITE, 200, 3, 0, 0, 1, 0, 0, 0);
		send(FN_READ, 0, 0, 0, 0, 0, 0, 0, 0);
		send(FN_READ, 159, 159, 0, 0, 0, 0, 0, 0);
		send(FN_READ, 160, 0, 0, 0, 0, 0, 0, 0);
		send(FN_READ, 0, 255, 0, 0, 0, 0, 0, 0);
		send(FN_CONTR, 0, 0, 0, 0, 0, 0, 0, 0);
		send(FN_CONTR, 0, 0, 0, 0, 0, 0, 0, 10);
		send(FN_CONTR, 0, 0, 0, 0, 0, 0, 0, 255);
		send(FN_STEP, 0, 0, 0, 0, 0, 0, 0, 0);
		send(FN_AREA, 255, 255, 158, 150, 0, 0, 0, 0);
		repeat (12) send(FN_STEP, 0, 0, 0, 0, 0, 0, 0, 0);
		send(FN_AREA, 0, 0, 0, 2, 0, 0, 0, 0);
		send(FN_WRITE, 5, 5, 0, 0, 8'h00, 0, 0, 0);
		send(FN_CLEAR, 0, 0, 0, 0, 0, 158, 255, 0);
		send(FN_CLEAR, 0, 0, 0, 0, 0, 200, 5, 0);
		send(FN_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
		send(FN_READ, 159, 159, 0, 0, 0, 0, 0, 0);
		send(3'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		// random mix: small areas and steps through them, now and then a full refresh
		n = 0;
		while (n < 1300) begin
			f = $urandom_range(0, 99);
			if (f < 25) send(FN_WRITE, coord(), coord(), 0, 0, 8'($urandom), 0, 0, 0);
			else if (f < 35) send(FN_READ, coord(), coord(), 0, 0, 0, 0, 0, 0);
			else if (f < 37) send(FN_CLEAR, 0, 0, 0, 0, 0, coord(),
				8'($urandom_range(0, 4)), 0);
			else if (f < 40) send_rand(FN_CONTR);
			else if (f < 46) begin
				logic [7:0] ax, ay;
				ax = coord(); ay = coord();
				send(FN_AREA, ax, ay, 8'(ax + $urandom_range(0, 3)),
					8'(ay + $urandom_range(0, 7)), 0, 0, 0, 0);
			end
			else if (f == 46 && $urandom_range(0, 9) == 0) send_rand(FN_FULL);
			else if (f < 49) send_rand(3'(f == 47 ? 7 : FN_AREA));
			else send_rand(FN_STEP);
			n++;
		end
		// a full refresh through its first rows and pad bytes
		send_rand(FN_FULL);
		repeat (200) send(FN_STEP, 0, 0, 0, 0, 0, 0, 0, 0);
		s_axis_tvalid <= 0;
		stim_done = 1;
		while (fb.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end
endmodule
